/* hw/rtl/cubemap_pixel_ray_direction_macros.svh */
// Assertion macros for the checks in the top-level file.
`ifndef CUBEMAP_PIXEL_RAY_DIRECTION_MACROS_SVH
`define CUBEMAP_PIXEL_RAY_DIRECTION_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define CPR_ASSERT_SAME(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("cpr: same-cycle check failed");

// The condition must hold in the cycle after the trigger.
`define CPR_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("cpr: next-cycle check failed");

`endif

/* hw/rtl/cpr_pkg.sv */
package cpr_pkg;

   // Field widths of the channels and the configuration port.
   localparam int COL_W      = 12;
   localparam int ROW_W      = 15;
   localparam int FACE_W     = 3;
   localparam int DIR_W      = 16;
   localparam int WIDTH_W    = 13;
   localparam int HEIGHT_W   = 15;
   localparam int FSIZE_W    = 13;
   localparam int CSR_DATA_W = 15;
   localparam int CSR_IDX_W  = 1;

   // Internal arithmetic widths.
   localparam int MULT_W = 16;
   localparam int UNUM_W = 14;
   localparam int VNUM_W = 17;
   localparam int A_W    = 27;
   localparam int B_W    = 31;
   localparam int C_W    = 26;
   localparam int SQ_AC_W = 52;
   localparam int S_W    = 60;
   localparam int LANES  = 3;

   localparam int DIR_FRAC_BITS_DEF = 15;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   // Reset values: width 512, face size 3072 / 6.
   localparam logic [WIDTH_W-1:0] WIDTH_RESET = 13'd512;
   localparam logic [FSIZE_W-1:0] FSIZE_RESET = 13'd512;

   // Height / 6 as multiply by 10923 and shift by 16, exact below 32768.
   localparam logic [13:0] DIV6_RECIP = 14'd10923;
   localparam int DIV6_SHIFT = 16;
   localparam int DIV6_PROD_W = HEIGHT_W + 14;

   // Saturation limits of a direction component.
   localparam int DIR_POS_LIM = 32767;
   localparam int DIR_NEG_LIM = 32768;
   localparam logic [DIR_W-1:0] DIR_MAX = 16'h7FFF;
   localparam logic [DIR_W-1:0] DIR_MIN = 16'h8000;

   typedef enum logic [FACE_W-1:0] {
      FACE_POS_X = 3'd0,
      FACE_NEG_X = 3'd1,
      FACE_POS_Y = 3'd2,
      FACE_NEG_Y = 3'd3,
      FACE_POS_Z = 3'd4,
      FACE_NEG_Z = 3'd5
   } face_type;

   // Side information that travels with an item through the pipeline.
   typedef struct packed {
      face_type           face;
      logic [LANES-1:0]   neg;
   } cpr_tag_type;

endpackage

/* hw/rtl/cpr_if.sv */
// Pixel request channel.
interface cpr_req_if;
   logic                      valid;
   logic                      ready;
   logic [cpr_pkg::COL_W-1:0] pixel_col;
   logic [cpr_pkg::ROW_W-1:0] pixel_row;

   modport source (output valid, output pixel_col, output pixel_row, input ready);
   modport sink (input valid, input pixel_col, input pixel_row, output ready);
endinterface

// Ray direction result channel.
interface cpr_rsp_if;
   logic                              valid;
   logic                              ready;
   logic        [cpr_pkg::FACE_W-1:0] face_index;
   logic signed [cpr_pkg::DIR_W-1:0]  dir_x;
   logic signed [cpr_pkg::DIR_W-1:0]  dir_y;
   logic signed [cpr_pkg::DIR_W-1:0]  dir_z;

   modport source (output valid, output face_index, output dir_x, output dir_y,
                   output dir_z, input ready);
   modport sink (input valid, input face_index, input dir_x, input dir_y,
                 input dir_z, output ready);
endinterface

/* hw/rtl/cpr_front.sv */
// Front end: face selection, local vector, rotation signs and squared terms.
module cpr_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  logic [cpr_pkg::COL_W-1:0]           pixel_col,
   input  logic [cpr_pkg::ROW_W-1:0]           pixel_row,
   input  logic [cpr_pkg::WIDTH_W-1:0]         img_width,
   input  logic [cpr_pkg::FSIZE_W-1:0]         fsize,
   output logic                                out_valid,
   output cpr_pkg::cpr_tag_type                out_tag,
   output logic [cpr_pkg::S_W-1:0]             out_s,
   output logic [cpr_pkg::S_W-1:0]             out_d2 [cpr_pkg::LANES]
);

   localparam int MW = cpr_pkg::MULT_W;

   logic [5:0] valid_ff;

   // Stage 1 registers.
   logic [cpr_pkg::COL_W-1:0] s1_col_ff;
   logic [cpr_pkg::ROW_W-1:0] s1_row_ff;
   logic [MW-1:0]             s1_mult_ff [5];
   logic [MW-1:0]             mult_in [5];

   // Stage 2 registers.
   cpr_pkg::face_type                s2_face_ff, s2_face_in;
   logic [cpr_pkg::ROW_W-1:0]        s2_r_ff, s2_r_in;
   logic signed [cpr_pkg::UNUM_W-1:0] s2_unum_ff, s2_unum_in;
   logic [MW-1:0]                    base;
   logic [MW-1:0]                    row_ext;

   // Stage 3 registers.
   cpr_pkg::face_type                 s3_face_ff;
   logic signed [cpr_pkg::A_W-1:0]    s3_a_ff, s3_a_in;
   logic signed [cpr_pkg::VNUM_W-1:0] s3_vnum_ff, s3_vnum_in;
   logic [cpr_pkg::C_W-1:0]           s3_c_ff, s3_c_in;
   logic signed [cpr_pkg::A_W-1:0]    u_ext, f_ext;

   // Stage 4 registers.
   cpr_pkg::face_type              s4_face_ff;
   logic signed [cpr_pkg::A_W-1:0] s4_a_ff;
   logic [cpr_pkg::C_W-1:0]        s4_c_ff;
   logic signed [cpr_pkg::B_W-1:0] s4_b_ff, s4_b_in;
   logic signed [cpr_pkg::B_W-1:0] v_ext, w_ext;

   // Stage 5 registers.
   cpr_pkg::cpr_tag_type           s5_tag_ff, s5_tag_in;
   logic [cpr_pkg::SQ_AC_W-1:0]    s5_asq_ff, s5_csq_ff;
   logic [cpr_pkg::S_W-1:0]        s5_bsq_ff;
   logic signed [53:0]             asq_w;
   logic signed [61:0]             bsq_w;
   logic [cpr_pkg::SQ_AC_W-1:0]    csq_w;
   logic                           sa, sb;

   // Stage 6 registers.
   cpr_pkg::cpr_tag_type    s6_tag_ff;
   logic [cpr_pkg::S_W-1:0] s6_s_ff, s6_s_in;
   logic [cpr_pkg::S_W-1:0] s6_d2_ff [cpr_pkg::LANES];
   logic [cpr_pkg::S_W-1:0] s6_d2_in [cpr_pkg::LANES];
   logic [cpr_pkg::S_W-1:0] asq_x, csq_x;

   // Valid bits step along with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[4:0], in_valid};
      end
   end

   // Face boundaries: multiples one to five of the face size.
   always_comb begin
      mult_in[0] = MW'(fsize);
      mult_in[1] = MW'({fsize, 1'b0});
      mult_in[2] = MW'(fsize) + MW'({fsize, 1'b0});
      mult_in[3] = MW'({fsize, 2'b00});
      mult_in[4] = MW'({fsize, 2'b00}) + MW'(fsize);
   end

   // Face index, row within the face and horizontal numerator.
   always_comb begin
      row_ext = MW'(s1_row_ff);
      if (row_ext >= s1_mult_ff[4]) begin
         s2_face_in = cpr_pkg::FACE_NEG_Z;
         base       = s1_mult_ff[4];
      end else if (row_ext >= s1_mult_ff[3]) begin
         s2_face_in = cpr_pkg::FACE_POS_Z;
         base       = s1_mult_ff[3];
      end else if (row_ext >= s1_mult_ff[2]) begin
         s2_face_in = cpr_pkg::FACE_NEG_Y;
         base       = s1_mult_ff[2];
      end else if (row_ext >= s1_mult_ff[1]) begin
         s2_face_in = cpr_pkg::FACE_POS_Y;
         base       = s1_mult_ff[1];
      end else if (row_ext >= s1_mult_ff[0]) begin
         s2_face_in = cpr_pkg::FACE_NEG_X;
         base       = s1_mult_ff[0];
      end else begin
         s2_face_in = cpr_pkg::FACE_POS_X;
         base       = '0;
      end
      s2_r_in    = cpr_pkg::ROW_W'(row_ext - base);
      s2_unum_in = {1'b0, s1_col_ff, 1'b0} - {1'b0, img_width};
   end

   // Scaled local vector components a and c, and the vertical numerator.
   always_comb begin
      u_ext      = cpr_pkg::A_W'(s2_unum_ff);
      f_ext      = cpr_pkg::A_W'(fsize);
      s3_a_in    = u_ext * f_ext;
      s3_vnum_in = {1'b0, s2_r_ff, 1'b0} - cpr_pkg::VNUM_W'(fsize);
      s3_c_in    = cpr_pkg::C_W'(img_width) * cpr_pkg::C_W'(fsize);
   end

   // Scaled component b.
   always_comb begin
      v_ext   = cpr_pkg::B_W'(s3_vnum_ff);
      w_ext   = cpr_pkg::B_W'(img_width);
      s4_b_in = v_ext * w_ext;
   end

   // Squares and the sign of each rotated component.
   always_comb begin
      asq_w = s4_a_ff * s4_a_ff;
      bsq_w = s4_b_ff * s4_b_ff;
      csq_w = cpr_pkg::SQ_AC_W'(s4_c_ff) * cpr_pkg::SQ_AC_W'(s4_c_ff);
      sa    = s4_a_ff[cpr_pkg::A_W-1];
      sb    = s4_b_ff[cpr_pkg::B_W-1];
      s5_tag_in.face = s4_face_ff;
      unique case (s4_face_ff)
         cpr_pkg::FACE_POS_X: s5_tag_in.neg = {~sa, ~sb, 1'b0};
         cpr_pkg::FACE_NEG_X: s5_tag_in.neg = {sa, ~sb, 1'b1};
         cpr_pkg::FACE_POS_Y: s5_tag_in.neg = {sb, 1'b0, sa};
         cpr_pkg::FACE_NEG_Y: s5_tag_in.neg = {~sb, 1'b1, sa};
         cpr_pkg::FACE_POS_Z: s5_tag_in.neg = {1'b0, ~sb, sa};
         cpr_pkg::FACE_NEG_Z: s5_tag_in.neg = {1'b1, ~sb, ~sa};
         default:             s5_tag_in.neg = '0;
      endcase
   end

   // Squared length and the squared rotated components (lane 0 is x).
   always_comb begin
      asq_x  = cpr_pkg::S_W'(s5_asq_ff);
      csq_x  = cpr_pkg::S_W'(s5_csq_ff);
      s6_s_in = asq_x + s5_bsq_ff + csq_x;
      case (s5_tag_ff.face) inside
         cpr_pkg::FACE_POS_X, cpr_pkg::FACE_NEG_X: begin
            s6_d2_in[0] = csq_x;
            s6_d2_in[1] = s5_bsq_ff;
            s6_d2_in[2] = asq_x;
         end
         cpr_pkg::FACE_POS_Y, cpr_pkg::FACE_NEG_Y: begin
            s6_d2_in[0] = asq_x;
            s6_d2_in[1] = csq_x;
            s6_d2_in[2] = s5_bsq_ff;
         end
         default: begin
            s6_d2_in[0] = asq_x;
            s6_d2_in[1] = s5_bsq_ff;
            s6_d2_in[2] = csq_x;
         end
      endcase
   end

   // Payload registers of all six stages.
   always_ff @(posedge clock) begin
      if (en) begin
         s1_col_ff  <= pixel_col;
         s1_row_ff  <= pixel_row;
         s1_mult_ff <= mult_in;
         s2_face_ff <= s2_face_in;
         s2_r_ff    <= s2_r_in;
         s2_unum_ff <= s2_unum_in;
         s3_face_ff <= s2_face_ff;
         s3_a_ff    <= s3_a_in;
         s3_vnum_ff <= s3_vnum_in;
         s3_c_ff    <= s3_c_in;
         s4_face_ff <= s3_face_ff;
         s4_a_ff    <= s3_a_ff;
         s4_c_ff    <= s3_c_ff;
         s4_b_ff    <= s4_b_in;
         s5_tag_ff  <= s5_tag_in;
         s5_asq_ff  <= asq_w[cpr_pkg::SQ_AC_W-1:0];
         s5_bsq_ff  <= bsq_w[cpr_pkg::S_W-1:0];
         s5_csq_ff  <= csq_w;
         s6_tag_ff  <= s5_tag_ff;
         s6_s_ff    <= s6_s_in;
         s6_d2_ff   <= s6_d2_in;
      end
   end

   assign out_valid = valid_ff[5];
   assign out_tag   = s6_tag_ff;
   assign out_s     = s6_s_ff;
   assign out_d2    = s6_d2_ff;

endmodule

/* hw/rtl/cpr_norm.sv */
// Normalisation: per lane a pipelined restoring divider gives
// floor(d^2 * 2^(2F+2) / s), a pipelined square root follows, and the last
// stage rounds, applies the sign and saturates.
module cpr_norm #(
   parameter int FRAC_BITS = cpr_pkg::DIR_FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  cpr_pkg::cpr_tag_type          in_tag,
   input  logic [cpr_pkg::S_W-1:0]       in_s,
   input  logic [cpr_pkg::S_W-1:0]       in_d2 [cpr_pkg::LANES],
   output logic                          out_valid,
   output cpr_pkg::face_type             out_face,
   output logic [cpr_pkg::DIR_W-1:0]     out_dir [cpr_pkg::LANES]
);

   localparam int S_W     = cpr_pkg::S_W;
   localparam int LANES   = cpr_pkg::LANES;
   localparam int Q_BITS  = 2 * FRAC_BITS + 3;
   localparam int RT_BITS = FRAC_BITS + 2;
   localparam int Y_W     = 2 * RT_BITS;
   localparam int SR_W    = RT_BITS + 3;
   localparam int QX_W    = (RT_BITS > 17) ? RT_BITS : 17;

   // Divider stages, one quotient bit each.
   logic                 dv_valid_ff [Q_BITS];
   cpr_pkg::cpr_tag_type dv_tag_ff   [Q_BITS];
   logic [S_W-1:0]       dv_s_ff     [Q_BITS];
   logic [S_W-1:0]       dv_rem_ff   [LANES][Q_BITS];
   logic [S_W-1:0]       dv_rem_in   [LANES][Q_BITS];
   logic [Q_BITS-1:0]    dv_quo_ff   [LANES][Q_BITS];
   logic [Q_BITS-1:0]    dv_quo_in   [LANES][Q_BITS];

   // Square root stages, one root bit each.
   logic                 sq_valid_ff [RT_BITS];
   cpr_pkg::cpr_tag_type sq_tag_ff   [RT_BITS];
   logic [Y_W-1:0]       sq_y_ff     [LANES][RT_BITS];
   logic [Y_W-1:0]       sq_y_in     [LANES][RT_BITS];
   logic [SR_W-1:0]      sq_rem_ff   [LANES][RT_BITS];
   logic [SR_W-1:0]      sq_rem_in   [LANES][RT_BITS];
   logic [RT_BITS-1:0]   sq_root_ff  [LANES][RT_BITS];
   logic [RT_BITS-1:0]   sq_root_in  [LANES][RT_BITS];

   // Output register.
   logic                        out_valid_ff;
   cpr_pkg::face_type           out_face_ff;
   logic [cpr_pkg::DIR_W-1:0]   out_dir_ff [LANES];
   logic [cpr_pkg::DIR_W-1:0]   out_dir_in [LANES];

   // Restoring division: compare the doubled remainder against s.
   always_comb begin
      logic [S_W:0]       wide;
      logic [S_W:0]       diff;
      for (int l = 0; l < LANES; l++) begin
         wide = {1'b0, in_d2[l]};
         diff = wide - {1'b0, in_s};
         if (!diff[S_W]) begin
            dv_rem_in[l][0] = diff[S_W-1:0];
            dv_quo_in[l][0] = Q_BITS'(1);
         end else begin
            dv_rem_in[l][0] = in_d2[l];
            dv_quo_in[l][0] = '0;
         end
         for (int k = 1; k < Q_BITS; k++) begin
            wide = {dv_rem_ff[l][k-1], 1'b0};
            diff = wide - {1'b0, dv_s_ff[k-1]};
            if (!diff[S_W]) begin
               dv_rem_in[l][k] = diff[S_W-1:0];
               dv_quo_in[l][k] = {dv_quo_ff[l][k-1][Q_BITS-2:0], 1'b1};
            end else begin
               dv_rem_in[l][k] = wide[S_W-1:0];
               dv_quo_in[l][k] = {dv_quo_ff[l][k-1][Q_BITS-2:0], 1'b0};
            end
         end
      end
   end

   // Digit-by-digit square root, two radicand bits per stage.
   always_comb begin
      logic [Y_W-1:0]     y_cur;
      logic [SR_W-1:0]    rem_cur;
      logic [RT_BITS-1:0] root_cur;
      logic [SR_W-1:0]    shifted;
      logic [SR_W-1:0]    trial;
      for (int l = 0; l < LANES; l++) begin
         for (int j = 0; j < RT_BITS; j++) begin
            if (j == 0) begin
               y_cur    = Y_W'(dv_quo_ff[l][Q_BITS-1]);
               rem_cur  = '0;
               root_cur = '0;
            end else begin
               y_cur    = sq_y_ff[l][(j == 0) ? 0 : j - 1];
               rem_cur  = sq_rem_ff[l][(j == 0) ? 0 : j - 1];
               root_cur = sq_root_ff[l][(j == 0) ? 0 : j - 1];
            end
            shifted = {rem_cur[SR_W-3:0], y_cur[Y_W-1 -: 2]};
            trial   = SR_W'({root_cur, 2'b01});
            if (shifted >= trial) begin
               sq_rem_in[l][j]  = shifted - trial;
               sq_root_in[l][j] = {root_cur[RT_BITS-2:0], 1'b1};
            end else begin
               sq_rem_in[l][j]  = shifted;
               sq_root_in[l][j] = {root_cur[RT_BITS-2:0], 1'b0};
            end
            sq_y_in[l][j] = {y_cur[Y_W-3:0], 2'b00};
         end
      end
   end

   // Rounding to nearest, sign and saturation.
   always_comb begin
      logic [RT_BITS:0]   tp1;
      logic [QX_W-1:0]    qx;
      logic [QX_W-1:0]    nq;
      for (int l = 0; l < LANES; l++) begin
         tp1 = {1'b0, sq_root_ff[l][RT_BITS-1]} + (RT_BITS + 1)'(1);
         qx  = QX_W'(tp1[RT_BITS:1]);
         nq  = QX_W'(0) - qx;
         if (!sq_tag_ff[RT_BITS-1].neg[l]) begin
            out_dir_in[l] = (qx > QX_W'(cpr_pkg::DIR_POS_LIM)) ? cpr_pkg::DIR_MAX
                                                               : qx[cpr_pkg::DIR_W-1:0];
         end else begin
            out_dir_in[l] = (qx > QX_W'(cpr_pkg::DIR_NEG_LIM)) ? cpr_pkg::DIR_MIN
                                                               : nq[cpr_pkg::DIR_W-1:0];
         end
      end
   end

   // Valid bits of every stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < Q_BITS; k++) begin
            dv_valid_ff[k] <= 1'b0;
         end
         for (int j = 0; j < RT_BITS; j++) begin
            sq_valid_ff[j] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else if (en) begin
         dv_valid_ff[0] <= in_valid;
         for (int k = 1; k < Q_BITS; k++) begin
            dv_valid_ff[k] <= dv_valid_ff[k-1];
         end
         sq_valid_ff[0] <= dv_valid_ff[Q_BITS-1];
         for (int j = 1; j < RT_BITS; j++) begin
            sq_valid_ff[j] <= sq_valid_ff[j-1];
         end
         out_valid_ff <= sq_valid_ff[RT_BITS-1];
      end
   end

   // Payload of every stage.
   always_ff @(posedge clock) begin
      if (en) begin
         dv_tag_ff[0] <= in_tag;
         dv_s_ff[0]   <= in_s;
         for (int k = 1; k < Q_BITS; k++) begin
            dv_tag_ff[k] <= dv_tag_ff[k-1];
            dv_s_ff[k]   <= dv_s_ff[k-1];
         end
         dv_rem_ff <= dv_rem_in;
         dv_quo_ff <= dv_quo_in;
         sq_tag_ff[0] <= dv_tag_ff[Q_BITS-1];
         for (int j = 1; j < RT_BITS; j++) begin
            sq_tag_ff[j] <= sq_tag_ff[j-1];
         end
         sq_y_ff     <= sq_y_in;
         sq_rem_ff   <= sq_rem_in;
         sq_root_ff  <= sq_root_in;
         out_face_ff <= sq_tag_ff[RT_BITS-1].face;
         out_dir_ff  <= out_dir_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_face  = out_face_ff;
   assign out_dir   = out_dir_ff;

endmodule

/* hw/rtl/cubemap_pixel_ray_direction.sv */
// Throughput: one item per cycle; six front stages, one divider stage per quotient
// bit, one square root stage per root bit and a rounding stage form the pipeline.
// A stalled result halts the whole pipeline, which then takes no new item.
// Reset is synchronous: it empties the pipeline and sets width 512 and height 3072.
`include "cubemap_pixel_ray_direction_macros.svh"

module cubemap_pixel_ray_direction #(
   parameter int DIR_FRAC_BITS = cpr_pkg::DIR_FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   cpr_req_if.sink                           req_chan,
   cpr_rsp_if.source                         rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [cpr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cpr_pkg::CSR_DATA_W-1:0]    csr_wr_data
);

   logic [cpr_pkg::WIDTH_W-1:0]     width_ff, width_in;
   logic [cpr_pkg::FSIZE_W-1:0]     fsize_ff, fsize_in;
   logic [cpr_pkg::DIV6_PROD_W-1:0] div6_prod;
   logic                            en;

   logic                            fr_valid;
   cpr_pkg::cpr_tag_type            fr_tag;
   logic [cpr_pkg::S_W-1:0]         fr_s;
   logic [cpr_pkg::S_W-1:0]         fr_d2 [cpr_pkg::LANES];

   logic                            nm_valid;
   cpr_pkg::face_type               nm_face;
   logic [cpr_pkg::DIR_W-1:0]       nm_dir [cpr_pkg::LANES];

   logic                            rsp_pos_x;
   logic                            width_zero_wr;

   // Effective width and face size; zero is taken as one.
   always_comb begin
      width_in  = csr_wr_data[cpr_pkg::WIDTH_W-1:0];
      if (width_in == '0) begin
         width_in = cpr_pkg::WIDTH_W'(1);
      end
      div6_prod = cpr_pkg::DIV6_PROD_W'(csr_wr_data)
                  * cpr_pkg::DIV6_PROD_W'(cpr_pkg::DIV6_RECIP);
      fsize_in  = div6_prod[cpr_pkg::DIV6_SHIFT +: cpr_pkg::FSIZE_W];
      if (fsize_in == '0) begin
         fsize_in = cpr_pkg::FSIZE_W'(1);
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= cpr_pkg::WIDTH_RESET;
         fsize_ff <= cpr_pkg::FSIZE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            cpr_pkg::CSR_IMAGE_WIDTH:  width_ff <= width_in;
            cpr_pkg::CSR_IMAGE_HEIGHT: fsize_ff <= fsize_in;
            default: ;
         endcase
      end
   end

   // The pipeline moves whenever the output register is free or being taken.
   // No item is taken while reset is held.
   assign en             = !nm_valid || rsp_chan.ready;
   assign req_chan.ready = en && !reset;

   cpr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_chan.valid),
      .pixel_col (req_chan.pixel_col),
      .pixel_row (req_chan.pixel_row),
      .img_width (width_ff),
      .fsize     (fsize_ff),
      .out_valid (fr_valid),
      .out_tag   (fr_tag),
      .out_s     (fr_s),
      .out_d2    (fr_d2)
   );

   cpr_norm #(
      .FRAC_BITS (DIR_FRAC_BITS)
   ) u_norm (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fr_valid),
      .in_tag    (fr_tag),
      .in_s      (fr_s),
      .in_d2     (fr_d2),
      .out_valid (nm_valid),
      .out_face  (nm_face),
      .out_dir   (nm_dir)
   );

   // Result channel.
   assign rsp_chan.valid      = nm_valid;
   assign rsp_chan.face_index = nm_face;
   assign rsp_chan.dir_x      = nm_dir[0];
   assign rsp_chan.dir_y      = nm_dir[1];
   assign rsp_chan.dir_z      = nm_dir[2];

   // Conditions watched by the checks below.
   assign rsp_pos_x     = rsp_chan.valid && (rsp_chan.face_index == cpr_pkg::FACE_POS_X);
   assign width_zero_wr = csr_wr_en && (csr_index == cpr_pkg::CSR_IMAGE_WIDTH)
                          && (csr_wr_data[cpr_pkg::WIDTH_W-1:0] == '0);

   // An empty output register never holds back the request side.
   `CPR_ASSERT_SAME(a_ready_when_empty, !rsp_chan.valid, req_chan.ready)
   // On the +x face the x component points along +x.
   `CPR_ASSERT_SAME(a_pos_x_facing, rsp_pos_x, !rsp_chan.dir_x[cpr_pkg::DIR_W-1])
   // A zero width is stored as one.
   `CPR_ASSERT_NEXT(a_zero_width, width_zero_wr, width_ff == cpr_pkg::WIDTH_W'(1))

endmodule
